FILE: design/pfla_pkg.sv
// Shared types and constants for the page free list allocator.
package pfla_pkg;

  // Geometry of the managed region
  localparam int MaxPages  = 4096;
  localparam int PageSize  = 4096;
  localparam int AddrW     = 48;
  localparam int IdxW      = $clog2(MaxPages);
  localparam int CountW    = $clog2(MaxPages + 1);
  localparam int PageShift = $clog2(PageSize);
  localparam int IdxHiW    = AddrW - PageShift;

  // Configuration port geometry
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 64;

  // Register reset values
  localparam logic [AddrW-1:0]  RegionBaseReset = '0;
  localparam logic [CountW-1:0] PageCountReset  = CountW'(MaxPages);

  // Request function codes
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // Register index as decoded from paddr
  localparam logic RegRegionBase = 1'b0;
  localparam logic RegPageCount  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_DOUBLE     = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  // One entry of the link memory
  typedef struct packed {
    logic            alloc;
    logic [IdxW-1:0] link;
  } link_entry_t;

  // Result of the free address check
  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] page;
  } chk_t;

  // Clamp a page count to the number of pages the memory holds
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] max_c;
    max_c = CountW'(MaxPages);
    return (cnt > max_c) ? max_c : cnt;
  endfunction

endpackage

FILE: design/pfla_link_ram.sv
// Single-port-write, single-port-read link memory with registered read data.
module pfla_link_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pfla_pkg::IdxW-1:0]     waddr_i,
  input  pfla_pkg::link_entry_t         wdata_i,
  input  logic                          re_i,
  input  logic [pfla_pkg::IdxW-1:0]     raddr_i,
  output pfla_pkg::link_entry_t         rdata_o
);
  import pfla_pkg::*;

  link_entry_t mem_q [MaxPages];
  link_entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pfla_addr_check.sv
// Alignment and range check of a free address, and its page index.
module pfla_addr_check (
  input  logic [pfla_pkg::AddrW-1:0]  addr_i,
  input  logic [pfla_pkg::AddrW-1:0]  region_base_i,
  input  logic [pfla_pkg::CountW-1:0] eff_count_i,
  output pfla_pkg::chk_t              chk_o
);
  import pfla_pkg::*;

  logic [AddrW-1:0]  diff;
  logic [IdxHiW-1:0] idx_hi;
  logic              below;
  logic              misaligned;
  logic              beyond;

  // Offset into the region, in pages
  assign diff       = addr_i - region_base_i;
  assign idx_hi     = diff[AddrW-1:PageShift];
  assign below      = addr_i < region_base_i;
  assign misaligned = addr_i[PageShift-1:0] != '0;
  assign beyond     = idx_hi >= IdxHiW'(eff_count_i);

  // Misalignment takes priority over range
  always_comb begin
    chk_o.page = idx_hi[IdxW-1:0];
    if (misaligned) begin
      chk_o.status = ST_MISALIGNED;
    end else if (below || beyond) begin
      chk_o.status = ST_RANGE;
    end else begin
      chk_o.status = ST_OK;
    end
  end

endmodule

FILE: design/page_free_list_allocator_unit.sv
// Top level of the page free list allocator: config registers, sequencer and results.
//
// Usage: raise start with func/addr while busy is low; the request is taken on that
// edge. func 0 pops the head page of the free list and returns its address,
// func 1 pushes the page at addr back onto the list after alignment, range and
// double-free checks. Each request yields exactly one result: alloc_addr_o,
// status_o and free_count_o are valid for one cycle while done_o is high.
// Each request is accepted in the idle state, where the page's link entry is read
// from the synchronous link memory; in the exec state that follows, head, counter
// and memory are updated and the result is registered. busy is high during exec,
// so a new request can be taken as the result shows.
// The receiver cannot stall; results are never held back.
// Reset: region_base 0, page_count 4096, all pages free and chained in order.
// A write of page_count restarts the list the same way. No clearing pass is run:
// a fill mark tracks how far the in-order chain has been consumed, and entries
// at or above it read as "link to next page, not allocated".
// Config is an APB-style port, 64-bit data, registers at byte 0 and 8.
module page_free_list_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic [pfla_pkg::AddrW-1:0]      addr_i,
  // Result channel
  output logic                            done_o,
  output logic [pfla_pkg::AddrW-1:0]      alloc_addr_o,
  output logic [2:0]                      status_o,
  output logic [pfla_pkg::CountW-1:0]     free_count_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfla_pkg::ApbAddrW-1:0]   paddr,
  input  logic [pfla_pkg::ApbDataW-1:0]   pwdata,
  output logic [pfla_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import pfla_pkg::*;

  // Configuration registers
  logic [AddrW-1:0]  base_q, base_d;
  logic [CountW-1:0] pcount_q, pcount_d;
  logic              cfg_wr;
  logic              restart;
  logic [CountW-1:0] new_eff;

  // List state
  logic [IdxW-1:0]   head_q, head_d;
  logic [CountW-1:0] free_q, free_d;
  logic [CountW-1:0] mark_q, mark_d;

  // Sequencer
  fsm_e              state_q, state_d;
  logic              accept;
  logic              exec;

  // Request registers
  logic              req_func_q;
  chk_t              req_chk_q;
  chk_t              chk;

  // Result registers
  logic              done_q;
  logic [AddrW-1:0]  alloc_addr_q, alloc_addr_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] fcount_q;

  // Memory interface
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  link_entry_t       mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  link_entry_t       mem_rdata;

  // Exec datapath
  logic [IdxW-1:0]   cur_idx;
  logic              untouched;
  logic [IdxW-1:0]   next_head;
  logic              cur_alloc;

  // Configuration write decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (paddr[3] == RegPageCount);
  assign new_eff = clamp_count(pwdata[CountW-1:0]);

  always_comb begin
    base_d   = base_q;
    pcount_d = pcount_q;
    if (cfg_wr) begin
      case (paddr[3])
        RegRegionBase: base_d   = pwdata[AddrW-1:0];
        RegPageCount:  pcount_d = pwdata[CountW-1:0];
        default:       base_d   = base_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3])
      RegRegionBase: prdata = {{(ApbDataW-AddrW){1'b0}}, base_q};
      RegPageCount:  prdata = {{(ApbDataW-CountW){1'b0}}, pcount_q};
      default:       prdata = '0;
    endcase
  end

  // Free address check on the incoming request
  pfla_addr_check u_check (
    .addr_i        (addr_i),
    .region_base_i (base_q),
    .eff_count_i   (clamp_count(pcount_q)),
    .chk_o         (chk)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (start) state_d = FSM_EXEC;
      FSM_EXEC: state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state_q)
      FSM_IDLE: busy = 1'b0;
      FSM_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

  assign accept = start && !busy;

  // Read the head entry on allocate, the target page entry on free
  assign mem_raddr = (func_i == FuncFree) ? chk.page : head_q;

  pfla_link_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Entries at or above the fill mark are read as their reset contents
  assign cur_idx   = (req_func_q == FuncFree) ? req_chk_q.page : head_q;
  assign untouched = {1'b0, cur_idx} >= mark_q;
  assign next_head = untouched ? (cur_idx + IdxW'(1)) : mem_rdata.link;
  assign cur_alloc = untouched ? 1'b0 : mem_rdata.alloc;

  // Execute the request: update list, memory and result
  always_comb begin
    head_d       = head_q;
    free_d       = free_q;
    mark_d       = mark_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_idx;
    mem_wdata    = '{alloc: 1'b0, link: head_q};
    alloc_addr_d = '0;
    status_d     = ST_OK;
    if (restart) begin
      head_d = '0;
      free_d = new_eff;
      mark_d = '0;
    end else if (exec) begin
      if (req_func_q == FuncAlloc) begin
        if (free_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          head_d       = next_head;
          free_d       = free_q - CountW'(1);
          mem_we       = 1'b1;
          mem_wdata    = '{alloc: 1'b1, link: next_head};
          alloc_addr_d = base_q + {{(IdxHiW-IdxW){1'b0}}, head_q, {PageShift{1'b0}}};
          if (untouched) begin
            mark_d = mark_q + CountW'(1);
          end
        end
      end else if (req_chk_q.status != ST_OK) begin
        status_d = req_chk_q.status;
      end else if (!cur_alloc) begin
        status_d = ST_DOUBLE;
      end else begin
        head_d    = cur_idx;
        free_d    = free_q + CountW'(1);
        mem_we    = 1'b1;
        mem_wdata = '{alloc: 1'b0, link: head_q};
      end
    end
  end

  // Control and list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      base_q   <= RegionBaseReset;
      pcount_q <= PageCountReset;
      head_q   <= '0;
      free_q   <= clamp_count(PageCountReset);
      mark_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      pcount_q <= pcount_d;
      head_q   <= head_d;
      free_q   <= free_d;
      mark_q   <= mark_d;
      done_q   <= exec;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_func_q <= func_i;
      req_chk_q  <= chk;
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (exec) begin
      alloc_addr_q <= alloc_addr_d;
      status_q     <= status_d;
      fcount_q     <= free_d;
    end
  end

  assign done_o       = done_q;
  assign alloc_addr_o = alloc_addr_q;
  assign status_o     = status_q;
  assign free_count_o = fcount_q;

endmodule

FILE: test/tb_page_free_list_allocator_unit.sv
// Testbench for the page free list allocator: directed and random requests checked against a predictor.
module tb_page_free_list_allocator_unit;
  import pfla_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam logic [ApbAddrW-1:0] RegionBaseAddr = ApbAddrW'(RegRegionBase) << 3;
  localparam logic [ApbAddrW-1:0] PageCountAddr  = ApbAddrW'(RegPageCount) << 3;

  typedef struct {
    logic             func;
    logic [AddrW-1:0] addr;
  } page_req_t;

  typedef struct {
    logic [AddrW-1:0]  alloc_addr;
    status_e           status;
    logic [CountW-1:0] free_count;
  } page_resp_t;

  // Clock, reset and DUT pins
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                req_start = 1'b0;
  logic                req_func = FuncAlloc;
  logic [AddrW-1:0]    req_addr = '0;
  logic                busy;
  logic                done_o;
  logic [AddrW-1:0]    alloc_addr_o;
  logic [2:0]          status_o;
  logic [CountW-1:0]   free_count_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Request and response stores
  page_req_t  pending_reqs[$];
  page_resp_t expected_resps[$];

  // Free list predictor state
  int unsigned       pl_link[MaxPages];
  bit                pl_alloc[MaxPages];
  int unsigned       pl_head;
  bit                pl_nonempty;
  int unsigned       pl_free;
  logic [AddrW-1:0]  cfg_base;
  logic [CountW-1:0] cfg_count;
  int unsigned       live_pages[$];

  // Bookkeeping
  bit took_req = 1'b0;
  int send_idle_pct = 18;
  int idle_cycles = 0;
  int mismatches = 0;
  int n_reqs = 0;
  int n_resps = 0;
  int n_settings = 0;
  int status_seen[5];

  page_free_list_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (req_start),
    .busy        (busy),
    .func_i      (req_func),
    .addr_i      (req_addr),
    .done_o      (done_o),
    .alloc_addr_o(alloc_addr_o),
    .status_o    (status_o),
    .free_count_o(free_count_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Generate the clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned eff_count();
    return (cfg_count > MaxPages) ? MaxPages : int'(cfg_count);
  endfunction

  // Rebuild the in-order chain with every page free
  function automatic void restart_free_list();
    for (int i = 0; i < MaxPages; i++) begin
      pl_link[i]  = i + 1;
      pl_alloc[i] = 1'b0;
    end
    pl_head     = 0;
    pl_free     = eff_count();
    pl_nonempty = (pl_free != 0);
    live_pages.delete();
  endfunction

  function automatic void apply_reg_write(logic idx, logic [ApbDataW-1:0] value);
    if (idx == RegRegionBase) begin
      cfg_base = value[AddrW-1:0];
    end else begin
      cfg_count = value[CountW-1:0];
      restart_free_list();
    end
  endfunction

  // Compute the response to one request and advance the free list
  function automatic page_resp_t predict_response(logic func, logic [AddrW-1:0] addr);
    page_resp_t  r;
    int unsigned page;
    logic [AddrW-1:0] offs;
    r.alloc_addr = '0;
    r.status     = ST_OK;
    if (func == FuncAlloc) begin
      if (!pl_nonempty || pl_head >= MaxPages) begin
        r.status = ST_EMPTY;
      end else begin
        page           = pl_head;
        pl_head        = pl_link[page];
        pl_alloc[page] = 1'b1;
        if (pl_free > 0) pl_free--;
        pl_nonempty  = (pl_free != 0);
        r.alloc_addr = cfg_base + AddrW'(page) * AddrW'(PageSize);
        live_pages.push_back(page);
      end
    end else begin
      offs = addr - cfg_base;
      if (addr[PageShift-1:0] != '0) begin
        r.status = ST_MISALIGNED;
      end else if (addr < cfg_base || offs / PageSize >= eff_count()) begin
        r.status = ST_RANGE;
      end else begin
        page = offs / PageSize;
        if (!pl_alloc[page]) begin
          r.status = ST_DOUBLE;
        end else begin
          pl_alloc[page] = 1'b0;
          pl_link[page]  = pl_head;
          pl_head        = page;
          pl_free++;
          pl_nonempty = 1'b1;
          for (int k = 0; k < live_pages.size(); k++) begin
            if (live_pages[k] == page) begin
              live_pages.delete(k);
              break;
            end
          end
        end
      end
    end
    r.free_count = pl_free[CountW-1:0];
    return r;
  endfunction

  // Lowest page-aligned address that maps to page idx
  function automatic logic [AddrW-1:0] addr_of_page(int unsigned idx);
    logic [AddrW-1:0] a;
    a = cfg_base + AddrW'(idx) * AddrW'(PageSize);
    if (a[PageShift-1:0] != '0) a = (a | AddrW'(PageSize - 1)) + 1'b1;
    return a;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s of result %0d: got 0x%0h, expected 0x%0h",
             field, n_resps, got, want);
    mismatches++;
  endtask

  task automatic push_req(logic func, logic [AddrW-1:0] addr);
    page_req_t rq;
    rq.func = func;
    rq.addr = addr;
    pending_reqs.push_back(rq);
  endtask

  // Mostly well-formed frees of live pages, plus allocates and broken frees
  task automatic queue_random_request(int alloc_pct);
    page_req_t   rq;
    int          roll;
    int unsigned n;
    n       = eff_count();
    rq.addr = AddrW'({$urandom(), $urandom()});
    if ($urandom_range(99) < alloc_pct) begin
      rq.func = FuncAlloc;
    end else begin
      rq.func = FuncFree;
      roll    = $urandom_range(99);
      if (roll < 80 && live_pages.size() > 0) begin
        rq.addr = addr_of_page(live_pages[$urandom_range(live_pages.size() - 1)]);
      end else if (roll < 86) begin
        rq.addr[PageShift-1:0] = PageShift'($urandom_range(PageSize - 1, 1));
      end else if (roll < 92) begin
        if ($urandom_range(1) && cfg_base >= PageSize) begin
          rq.addr = addr_of_page(0) - AddrW'(PageSize);
        end else begin
          rq.addr = addr_of_page(n + $urandom_range(3));
        end
      end else if (roll < 97 && n > 0) begin
        rq.addr = addr_of_page($urandom_range(n - 1));
      end else begin
        rq.addr[PageShift-1:0] = '0;
      end
    end
    pending_reqs.push_back(rq);
  endtask

  // Wait until every request is accepted and answered, then let the pipe drain
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_reqs.size() != 0 || req_start || expected_resps.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == RegRegionBase) ? RegionBaseAddr : PageCountAddr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg_write(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_region(logic [AddrW-1:0] base, logic [CountW-1:0] count);
    wait_idle();
    write_reg(RegRegionBase, ApbDataW'(base));
    write_reg(RegPageCount, ApbDataW'(count));
    n_settings++;
  endtask

  task automatic run_phase(logic [AddrW-1:0] base, logic [CountW-1:0] count,
                           int idle_pct, int n_items);
    int alloc_pct;
    set_region(base, count);
    send_idle_pct = idle_pct;
    alloc_pct     = 50;
    for (int i = 0; i < n_items; i++) begin
      // Shift the mix now and then so the list drains and refills
      if (i % 50 == 0) alloc_pct = 30 + 20 * $urandom_range(2);
      while (pending_reqs.size() != 0) begin
        @(posedge clk_i);
        #1;
      end
      queue_random_request(alloc_pct);
    end
  endtask

  // Drive requests at the falling edge; hold each one until it is taken
  always @(negedge clk_i) begin
    page_req_t nxt;
    if (rst_ni && (!req_start || took_req)) begin
      if ($urandom_range(99) < send_idle_pct || pending_reqs.size() == 0) begin
        req_start <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        req_start <= 1'b1;
        req_func  <= nxt.func;
        req_addr  <= nxt.addr;
      end
    end
  end

  // Check results, predict accepted requests and watch for a stall
  always @(posedge clk_i) begin
    page_resp_t want;
    if (rst_ni) begin
      took_req = req_start && !busy;
      if (done_o) begin
        n_resps++;
        if (expected_resps.size() == 0) begin
          report_mismatch("strobe (no request outstanding)", 64'(done_o), 64'(0));
        end else begin
          want = expected_resps.pop_front();
          status_seen[int'(want.status)]++;
          if (alloc_addr_o !== want.alloc_addr)
            report_mismatch("alloc_addr", 64'(alloc_addr_o), 64'(want.alloc_addr));
          if (status_o !== want.status)
            report_mismatch("status", 64'(status_o), 64'(want.status));
          if (free_count_o !== want.free_count)
            report_mismatch("free_count", 64'(free_count_o), 64'(want.free_count));
        end
      end
      if (took_req) begin
        expected_resps.push_back(predict_response(req_func, req_addr));
        n_reqs++;
      end
      idle_cycles = (took_req || done_o) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: nothing accepted for %0d cycles", WatchdogLimit);
        $display("FAIL page_free_list_allocator_unit");
        $finish;
      end
    end
  end

  initial begin
    cfg_base  = RegionBaseReset;
    cfg_count = PageCountReset;
    restart_free_list();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset region: alloc, free, double free, misaligned and out-of-range frees
    push_req(FuncAlloc, '0);
    push_req(FuncAlloc, '1);
    push_req(FuncFree, AddrW'(PageSize));
    push_req(FuncFree, AddrW'(PageSize));
    push_req(FuncFree, AddrW'(1));
    push_req(FuncFree, '1);
    push_req(FuncFree, AddrW'(MaxPages) * AddrW'(PageSize));
    push_req(FuncFree, 48'hFFFF_FFFF_F000);
    push_req(FuncFree, AddrW'(5 * PageSize));
    push_req(FuncFree, '0);

    // No pages: list empty, every free out of range
    set_region('0, '0);
    push_req(FuncAlloc, '0);
    push_req(FuncFree, '0);

    // Region at the top of the address space: page address wraps
    set_region(48'hFFFF_FFFF_E000, CountW'(3));
    push_req(FuncAlloc, '0);
    push_req(FuncAlloc, '0);
    push_req(FuncAlloc, '0);
    push_req(FuncAlloc, '0);
    push_req(FuncFree, '0);
    push_req(FuncFree, 48'hFFFF_FFFF_F000);
    push_req(FuncAlloc, '0);

    // Single page
    set_region('0, CountW'(1));
    push_req(FuncAlloc, '0);
    push_req(FuncAlloc, '0);
    push_req(FuncFree, '0);

    // Random phases over several region settings
    run_phase(AddrW'({$urandom(), $urandom()}) & ~AddrW'(PageSize - 1),
              CountW'(16), 18, 300);
    run_phase(48'hFFFF_FF80_0000, CountW'(MaxPages), 18, 250);
    run_phase(AddrW'({$urandom_range(32767), $urandom()}), '1, 87, 200);
    run_phase('0, CountW'(1), 87, 150);
    run_phase('1, '0, 0, 100);
    run_phase(AddrW'({$urandom(), $urandom()}) & ~AddrW'(PageSize - 1),
              CountW'(37), 0, 500);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d requests and %0d results over %0d region settings",
             n_reqs, n_resps, n_settings + 1);
    $display("status mix ok/empty/misaligned/range/double: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (mismatches == 0) begin
      $display("PASS page_free_list_allocator_unit");
    end else begin
      $display("FAIL page_free_list_allocator_unit");
    end
    $finish;
  end

endmodule
